// ----- rtl/fdq_pkg.sv -----
// ----------------------------------------------------------------------------
// fdq_pkg: shared types and constants of the decimating Q15 filter
// Sample and accumulator types, filter geometry and the folded coefficient set.
// ----------------------------------------------------------------------------
`default_nettype none

package fdq_pkg;

  localparam int SMP_W      = 16;
  localparam int TAP_COUNT  = 15;
  localparam int HIST_LEN   = TAP_COUNT - 1;
  localparam int PAIR_COUNT = (TAP_COUNT + 1) / 2;
  localparam int SUM_N      = PAIR_COUNT / 2;
  localparam int PRE_W      = SMP_W + 1;
  localparam int ACC_W      = 32;
  localparam int Q_SHIFT    = 15;

  typedef logic signed [SMP_W-1:0] smp_t;
  typedef logic signed [PRE_W-1:0] pre_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef smp_t hist_t [HIST_LEN];
  typedef pre_t pre_arr_t [PAIR_COUNT];
  typedef acc_t acc_arr_t [PAIR_COUNT];

  // One coefficient for each mirrored pair; the last entry is the centre tap.
  localparam acc_t COEF_PAIR [PAIR_COUNT] = '{
    -32'sd30, 32'sd197, 32'sd310, -32'sd781,
    -32'sd1885, 32'sd1587, 32'sd9777, 32'sd14418
  };

  localparam acc_t Q_MAX = 32'sd32767;
  localparam acc_t Q_MIN = -32'sd32768;

  // Item handed from the history line to the arithmetic pipeline.
  typedef struct packed {
    logic load;
    logic dec;
    smp_t sample;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/fdq_if.sv -----
// ----------------------------------------------------------------------------
// fdq_if: stream channels of the decimating Q15 filter
// Valid/ready channels for input samples and for filtered results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fdq_in_if;
  logic          valid;
  logic          ready;
  fdq_pkg::smp_t sample;
  logic          frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface fdq_out_if;
  logic          valid;
  logic          ready;
  fdq_pkg::smp_t out_sample;

  modport source (output valid, output out_sample, input ready);
  modport sink   (input valid, input out_sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/fir_decimate_by_two_q15.sv -----
// ----------------------------------------------------------------------------
// fir_decimate_by_two_q15: decimate-by-two 15-tap Q15 low-pass front end
// Filters and halves the sample rate of a PCM stream, or passes it unchanged.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                        Transfer
//  in_chan  in   sample[15:0], frame_start      valid & ready
//  out_chan out  out_sample[15:0]               valid & ready
//  cfg_*    in   cfg_wr_data (decimate_enable)  cfg_wr_en
//
//  One sample is taken in every cycle while the pipeline has room.
//  A result is presented once its sample has passed the pre-add, constant
//  multiply and pair-sum registers and then the final sum and saturation
//  into the result register. Each stage stalls only when the stage after
//  it is full. Reset clears the history line, the phase and the mode to bypass.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_decimate_by_two_q15 (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fdq_in_if.sink      in_chan,
  fdq_out_if.source   out_chan,
  input  wire logic   cfg_wr_en,
  input  wire logic   cfg_wr_data
);

  logic           decimate_enable_r;
  logic           in_ready;
  logic           accept;
  fdq_pkg::hist_t hist;
  fdq_pkg::item_t item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimate_enable_r <= 1'b0;
    end else if (cfg_wr_en) begin
      decimate_enable_r <= cfg_wr_data;
    end
  end

  assign in_chan.ready = in_ready;
  assign accept        = in_chan.valid && in_ready;

  fdq_hist u_hist (
    .clk             (clk),
    .rst_n           (rst_n),
    .decimate_enable (decimate_enable_r),
    .accept          (accept),
    .sample          (in_chan.sample),
    .frame_start     (in_chan.frame_start),
    .hist            (hist),
    .item            (item)
  );

  fdq_fir u_fir (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .hist       (hist),
    .in_ready   (in_ready),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_sample (out_chan.out_sample)
  );

endmodule

`default_nettype wire

// ----- rtl/fdq_hist.sv -----
// ----------------------------------------------------------------------------
// fdq_hist: sample history line and output phase tracking
// Holds the 14 most recent decimate-mode samples and decides which accepted
// samples produce a result.
// ----------------------------------------------------------------------------
`default_nettype none

module fdq_hist (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           decimate_enable,
  input  wire logic           accept,
  input  wire fdq_pkg::smp_t  sample,
  input  wire logic           frame_start,
  output fdq_pkg::hist_t      hist,
  output fdq_pkg::item_t      item
);

  fdq_pkg::hist_t hist_r;
  logic           phase_odd_r;
  logic           even;

  assign even = frame_start || !phase_odd_r;
  assign hist = hist_r;

  always_comb begin
    item.load   = accept && (!decimate_enable || even);
    item.dec    = decimate_enable;
    item.sample = sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_odd_r <= 1'b0;
      for (int i = 0; i < fdq_pkg::HIST_LEN; i++) begin
        hist_r[i] <= '0;
      end
    end else if (accept) begin
      phase_odd_r <= even;
      // The history only moves in decimate mode; bypass leaves it as it is.
      if (decimate_enable) begin
        for (int i = 0; i < fdq_pkg::HIST_LEN - 1; i++) begin
          hist_r[i] <= hist_r[i+1];
        end
        hist_r[fdq_pkg::HIST_LEN-1] <= sample;
      end
    end
  end

`ifndef SYNTHESIS
  a_odd_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    accept && decimate_enable && !frame_start && phase_odd_r |-> !item.load)
    else $error("odd-position sample produced a result");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && frame_start |=> phase_odd_r)
    else $error("frame start did not restart the phase");

  a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> phase_odd_r == $past(phase_odd_r))
    else $error("phase moved without a transfer");
`endif

endmodule

`default_nettype wire

// ----- rtl/fdq_fir.sv -----
// ----------------------------------------------------------------------------
// fdq_fir: folded symmetric FIR pipeline with result register
// Pre-adds mirrored taps, multiplies by constants, sums, shifts by 15 and
// saturates. Each stage stalls only when the stage after it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module fdq_fir (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire fdq_pkg::item_t item,
  input  wire fdq_pkg::hist_t hist,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output fdq_pkg::smp_t       out_sample
);

  // Stage 1: pre-added pairs.
  logic              v1_r, dec1_r;
  fdq_pkg::smp_t     smp1_r;
  fdq_pkg::pre_arr_t pre1_r, pre1_nxt;
  // Stage 2: products.
  logic              v2_r, dec2_r;
  fdq_pkg::smp_t     smp2_r;
  fdq_pkg::acc_arr_t prod2_r, prod2_nxt;
  // Stage 3: partial sums of product pairs.
  logic              v3_r, dec3_r;
  fdq_pkg::smp_t     smp3_r;
  fdq_pkg::acc_t     sum3_r [fdq_pkg::SUM_N];
  fdq_pkg::acc_t     sum3_nxt [fdq_pkg::SUM_N];
  // Result register.
  logic              out_valid_r;
  fdq_pkg::smp_t     out_sample_r, out_sample_nxt;

  logic rdy1, rdy2, rdy3, rdy_out;
  fdq_pkg::acc_t total, q;

  assign rdy_out  = !out_valid_r || out_ready;
  assign rdy3     = !v3_r || rdy_out;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // The newest sample takes the window slot just after the history.
  always_comb begin
    pre1_nxt[0] = fdq_pkg::pre_t'(hist[0]) + fdq_pkg::pre_t'(item.sample);
    for (int i = 1; i < fdq_pkg::PAIR_COUNT - 1; i++) begin
      pre1_nxt[i] = fdq_pkg::pre_t'(hist[i])
                  + fdq_pkg::pre_t'(hist[fdq_pkg::HIST_LEN-i]);
    end
    pre1_nxt[fdq_pkg::PAIR_COUNT-1] = fdq_pkg::pre_t'(hist[fdq_pkg::PAIR_COUNT-1]);
  end

  always_comb begin
    for (int i = 0; i < fdq_pkg::PAIR_COUNT; i++) begin
      prod2_nxt[i] = fdq_pkg::acc_t'(pre1_r[i]) * fdq_pkg::COEF_PAIR[i];
    end
  end

  always_comb begin
    for (int i = 0; i < fdq_pkg::SUM_N; i++) begin
      sum3_nxt[i] = prod2_r[2*i] + prod2_r[2*i+1];
    end
  end

  // The arithmetic shift rounds toward minus infinity.
  always_comb begin
    total = '0;
    for (int i = 0; i < fdq_pkg::SUM_N; i++) begin
      total = total + sum3_r[i];
    end
    q = total >>> fdq_pkg::Q_SHIFT;
    if (!dec3_r) begin
      out_sample_nxt = smp3_r;
    end else if (q > fdq_pkg::Q_MAX) begin
      out_sample_nxt = fdq_pkg::smp_t'(fdq_pkg::Q_MAX);
    end else if (q < fdq_pkg::Q_MIN) begin
      out_sample_nxt = fdq_pkg::smp_t'(fdq_pkg::Q_MIN);
    end else begin
      out_sample_nxt = q[fdq_pkg::SMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= item.load;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdy_out) begin
        out_valid_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dec1_r <= item.dec;
      smp1_r <= item.sample;
      pre1_r <= pre1_nxt;
    end
    if (rdy2) begin
      dec2_r  <= dec1_r;
      smp2_r  <= smp1_r;
      prod2_r <= prod2_nxt;
    end
    if (rdy3) begin
      dec3_r <= dec2_r;
      smp3_r <= smp2_r;
      sum3_r <= sum3_nxt;
    end
    if (rdy_out) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

`ifndef SYNTHESIS
  a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !rdy_out |=> v3_r)
    else $error("last stage lost an item while the result was stalled");

  a_bypass_value: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && rdy_out && !dec3_r |=> out_sample_r == $past(smp3_r))
    else $error("bypass sample altered");

  a_sat_high: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && rdy_out && dec3_r && q > fdq_pkg::Q_MAX
      |=> out_sample_r == fdq_pkg::smp_t'(fdq_pkg::Q_MAX))
    else $error("positive overflow not saturated");
`endif

endmodule

`default_nettype wire
